// ===== sv/ipv4tp_pkg.sv =====
// Package for the IPv4 text parser and matcher.
// Holds the channel payload types, status codes and register indexes; no dependencies.
package ipv4tp_pkg;

  localparam int CHAR_W    = 8;
  localparam int ADDR_W    = 32;
  localparam int STATUS_W  = 2;
  localparam int KEY_W     = 8;
  localparam int CFG_IDX_W = 2;
  localparam int LEN_W     = 5;
  localparam int CNT_W     = 3;

  localparam logic [CHAR_W-1:0] TAB_CODE   = 8'd9;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'd48;
  localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'd57;
  localparam logic [LEN_W-1:0]  MIN_LEN    = 5'd7;
  localparam logic [LEN_W-1:0]  MAX_LEN    = 5'd15;
  localparam logic [LEN_W-1:0]  LEN_SAT    = 5'd16;
  localparam logic [CNT_W-1:0]  NUM_OCTETS = 3'd4;

  localparam logic [KEY_W-1:0] FIRST_KEY_RST     = 8'd1;
  localparam logic [KEY_W-1:0] PAIR_KEY_HIGH_RST = 8'd46;
  localparam logic [KEY_W-1:0] PAIR_KEY_LOW_RST  = 8'd70;
  localparam logic [KEY_W-1:0] ANY_KEY_RST       = 8'd46;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_BAD_LEN   = 2'd1,
    ST_BAD_OCTET = 2'd2
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FIRST_KEY     = 2'd0,
    REG_PAIR_KEY_HIGH = 2'd1,
    REG_PAIR_KEY_LOW  = 2'd2,
    REG_ANY_KEY       = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [CHAR_W-1:0] char_code;
    logic              line_end;
  } in_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0]   address;
    logic [STATUS_W-1:0] status;
    logic                match_first;
    logic                match_pair;
    logic                match_any;
  } out_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0]   address;
    logic [STATUS_W-1:0] status;
  } line_rec_t;

  typedef struct packed {
    logic [KEY_W-1:0] first_key;
    logic [KEY_W-1:0] pair_key_high;
    logic [KEY_W-1:0] pair_key_low;
    logic [KEY_W-1:0] any_key;
  } cfg_keys_t;

endpackage

// ===== sv/ipv4tp_front.sv =====
// Front end: parses the characters of a line and emits one line record at line end.
// Depends on ipv4tp_pkg.
module ipv4tp_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  char_acc,
  input  ipv4tp_pkg::in_item_t  char_item,
  output logic                  rec_push,
  output ipv4tp_pkg::line_rec_t rec
);

  logic [ipv4tp_pkg::ADDR_W-1:0] addr_r, addr_nxt;
  logic [ipv4tp_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [7:0]                    val_r, val_nxt;
  logic                          ovf_r, ovf_nxt;
  logic                          indig_r, indig_nxt;
  logic                          failed_r, failed_nxt;
  logic [ipv4tp_pkg::LEN_W-1:0]  len_r, len_nxt;
  logic                          tab_r, tab_nxt;

  logic [ipv4tp_pkg::CHAR_W-1:0] c;
  logic                          is_digit;
  logic [3:0]                    dval;
  logic [11:0]                   acc;
  logic                          close_req;

  assign c        = char_item.char_code;
  assign is_digit = (c >= ipv4tp_pkg::CHAR_ZERO) && (c <= ipv4tp_pkg::CHAR_NINE);
  assign dval     = 4'(c - ipv4tp_pkg::CHAR_ZERO);
  assign acc      = 12'(val_r) * 12'd10 + 12'(dval);

  always_comb begin
    addr_nxt   = addr_r;
    cnt_nxt    = cnt_r;
    val_nxt    = val_r;
    ovf_nxt    = ovf_r;
    indig_nxt  = indig_r;
    failed_nxt = failed_r;
    len_nxt    = len_r;
    tab_nxt    = tab_r;
    close_req  = 1'b0;
    rec_push   = 1'b0;
    rec        = '0;
    if (char_acc) begin
      if (!tab_r) begin
        if (c == ipv4tp_pkg::TAB_CODE) begin
          tab_nxt = 1'b1;
        end else begin
          if (len_r < ipv4tp_pkg::LEN_SAT) begin
            len_nxt = len_r + 1'b1;
          end
          if (!failed_r && (cnt_r < ipv4tp_pkg::NUM_OCTETS)) begin
            if (indig_r) begin
              if (is_digit) begin
                if (acc > 12'd255) begin
                  ovf_nxt = 1'b1;
                end
                val_nxt = acc[7:0];
              end else begin
                close_req = 1'b1;
              end
            end else if (is_digit) begin
              indig_nxt = 1'b1;
              val_nxt   = {4'd0, dval};
              ovf_nxt   = 1'b0;
            end else begin
              failed_nxt = 1'b1;
            end
          end
        end
      end
      if (char_item.line_end && !failed_nxt && indig_nxt &&
          (cnt_nxt < ipv4tp_pkg::NUM_OCTETS)) begin
        close_req = 1'b1;
      end
      if (close_req) begin
        if (ovf_nxt) begin
          failed_nxt = 1'b1;
        end else begin
          case (cnt_nxt[1:0])
            2'd0:    addr_nxt[31:24] = val_nxt;
            2'd1:    addr_nxt[23:16] = val_nxt;
            2'd2:    addr_nxt[15:8]  = val_nxt;
            default: addr_nxt[7:0]   = val_nxt;
          endcase
          cnt_nxt = cnt_nxt + 1'b1;
        end
        indig_nxt = 1'b0;
        ovf_nxt   = 1'b0;
        val_nxt   = '0;
      end
      if (char_item.line_end) begin
        if (cnt_nxt < ipv4tp_pkg::NUM_OCTETS) begin
          failed_nxt = 1'b1;
        end
        rec_push = 1'b1;
        if ((len_nxt < ipv4tp_pkg::MIN_LEN) || (len_nxt > ipv4tp_pkg::MAX_LEN)) begin
          rec.address = '0;
          rec.status  = ipv4tp_pkg::ST_BAD_LEN;
        end else begin
          rec.address = addr_nxt;
          rec.status  = failed_nxt ? ipv4tp_pkg::ST_BAD_OCTET : ipv4tp_pkg::ST_OK;
        end
        addr_nxt   = '0;
        cnt_nxt    = '0;
        val_nxt    = '0;
        ovf_nxt    = 1'b0;
        indig_nxt  = 1'b0;
        failed_nxt = 1'b0;
        len_nxt    = '0;
        tab_nxt    = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r   <= '0;
      cnt_r    <= '0;
      val_r    <= '0;
      ovf_r    <= 1'b0;
      indig_r  <= 1'b0;
      failed_r <= 1'b0;
      len_r    <= '0;
      tab_r    <= 1'b0;
    end else begin
      addr_r   <= addr_nxt;
      cnt_r    <= cnt_nxt;
      val_r    <= val_nxt;
      ovf_r    <= ovf_nxt;
      indig_r  <= indig_nxt;
      failed_r <= failed_nxt;
      len_r    <= len_nxt;
      tab_r    <= tab_nxt;
    end
  end

endmodule

// ===== sv/ipv4tp_queue.sv =====
// Short register queue that decouples the front end from the back end.
// Generic in width and depth (depth of at least two); no package dependencies.
module ipv4tp_queue #(
  parameter int WIDTH = 34,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic             empty,
  output logic [WIDTH-1:0] rdata
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

// ===== sv/ipv4tp_back.sv =====
// Back end: compares a line record with the keys and holds the finished result.
// Depends on ipv4tp_pkg.
module ipv4tp_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  rec_avail,
  input  ipv4tp_pkg::line_rec_t rec,
  output logic                  rec_take,
  input  ipv4tp_pkg::cfg_keys_t keys,
  input  logic                  out_pop,
  output logic                  out_empty,
  output ipv4tp_pkg::out_item_t out_item
);

  logic                  valid_r, valid_nxt;
  ipv4tp_pkg::out_item_t res_r, res_nxt;
  logic [7:0]            o1, o2, o3, o4;

  assign o1 = rec.address[31:24];
  assign o2 = rec.address[23:16];
  assign o3 = rec.address[15:8];
  assign o4 = rec.address[7:0];

  assign out_empty = !valid_r;
  assign out_item  = res_r;
  assign rec_take  = rec_avail && (!valid_r || out_pop);

  always_comb begin
    valid_nxt = valid_r;
    res_nxt   = res_r;
    if (rec_take) begin
      valid_nxt           = 1'b1;
      res_nxt.address     = rec.address;
      res_nxt.status      = rec.status;
      res_nxt.match_first = (o1 == keys.first_key);
      res_nxt.match_pair  = (o1 == keys.pair_key_high) && (o2 == keys.pair_key_low);
      res_nxt.match_any   = (o1 == keys.any_key) || (o2 == keys.any_key) ||
                            (o3 == keys.any_key) || (o4 == keys.any_key);
    end else if (out_pop) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

endmodule

// ===== sv/ipv4_text_parse_and_match.sv =====
// Top level of the IPv4 text parser: key registers, front end, queue and back end.
// Depends on ipv4tp_pkg, ipv4tp_front, ipv4tp_queue and ipv4tp_back.
//
//   Channel  Handshake          Payload
//   in_      in_push / in_full  in_item (char_code, line_end)
//   out_     out_pop / out_empty out_item (address, status, three match flags)
//   cfg_     cfg_valid / cfg_ready cfg_index, cfg_data
//
// One character beat is taken per cycle unless the queue is full; the line record enters
// the queue in the same cycle as its last character; out_item is a registered output.
// Throughput is one beat per cycle unless the queue is full, set by the front-end parse.
// Reset is synchronous and active low; it clears parse and queue state, presets keys.
// A full queue stalls input; out_pop low only stalls input once the queue fills.
module ipv4_text_parse_and_match #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_push,
  output logic                                  in_full,
  input  ipv4tp_pkg::in_item_t                  in_item,
  output logic                                  out_empty,
  input  logic                                  out_pop,
  output ipv4tp_pkg::out_item_t                 out_item,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [ipv4tp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ipv4tp_pkg::KEY_W-1:0]          cfg_data
);

  ipv4tp_pkg::cfg_keys_t keys_r, keys_nxt;
  ipv4tp_pkg::line_rec_t front_rec, back_rec;
  logic                  char_acc;
  logic                  rec_push, q_full, q_empty, rec_take;

  assign cfg_ready = 1'b1;
  assign in_full   = q_full;
  assign char_acc  = in_push && !q_full;

  always_comb begin
    keys_nxt = keys_r;
    if (cfg_valid && cfg_ready) begin
      unique case (ipv4tp_pkg::cfg_reg_t'(cfg_index))
        ipv4tp_pkg::REG_FIRST_KEY:     keys_nxt.first_key     = cfg_data;
        ipv4tp_pkg::REG_PAIR_KEY_HIGH: keys_nxt.pair_key_high = cfg_data;
        ipv4tp_pkg::REG_PAIR_KEY_LOW:  keys_nxt.pair_key_low  = cfg_data;
        ipv4tp_pkg::REG_ANY_KEY:       keys_nxt.any_key       = cfg_data;
        default:                       keys_nxt = keys_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      keys_r.first_key     <= ipv4tp_pkg::FIRST_KEY_RST;
      keys_r.pair_key_high <= ipv4tp_pkg::PAIR_KEY_HIGH_RST;
      keys_r.pair_key_low  <= ipv4tp_pkg::PAIR_KEY_LOW_RST;
      keys_r.any_key       <= ipv4tp_pkg::ANY_KEY_RST;
    end else begin
      keys_r <= keys_nxt;
    end
  end

  ipv4tp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .char_acc  (char_acc),
    .char_item (in_item),
    .rec_push  (rec_push),
    .rec       (front_rec)
  );

  ipv4tp_queue #(
    .WIDTH ($bits(ipv4tp_pkg::line_rec_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (rec_push),
    .wdata (front_rec),
    .full  (q_full),
    .pop   (rec_take),
    .empty (q_empty),
    .rdata (back_rec)
  );

  ipv4tp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .rec_avail (!q_empty),
    .rec       (back_rec),
    .rec_take  (rec_take),
    .keys      (keys_r),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .out_item  (out_item)
  );

  a_rec_only_at_line_end: assert property (@(posedge clk) disable iff (!rst_n)
    rec_push |-> (char_acc && in_item.line_end))
    else $error("line record pushed without an accepted line end");

  a_bad_len_zero_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && (out_item.status == ipv4tp_pkg::ST_BAD_LEN)) |-> (out_item.address == '0))
    else $error("bad length result carries a nonzero address");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (out_item.status == ipv4tp_pkg::ST_OK ||
                    out_item.status == ipv4tp_pkg::ST_BAD_LEN ||
                    out_item.status == ipv4tp_pkg::ST_BAD_OCTET))
    else $error("result status outside the defined codes");

  a_take_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> ($stable(out_item) || $past(rec_take) == 1'b0))
    else $error("held result overwritten while stalled");

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for ipv4_text_parse_and_match: writes keys, drives text lines and
// result pops with random gaps, and checks every result against a built-in line parser.
// Depends on ipv4tp_pkg and the ipv4_text_parse_and_match RTL.
module testbench;

  localparam int CYCLE_LIMIT = 300000;
  localparam logic [ipv4tp_pkg::CHAR_W-1:0] DOT_CHAR = 8'h2E;

  class ipv4_addr_checker;
    logic [ipv4tp_pkg::KEY_W-1:0] first_key, pair_hi, pair_lo, any_key;
    logic [ipv4tp_pkg::ADDR_W-1:0] addr_acc;
    int octets, cur_val, field_len;
    bit ovf, in_digits, failed, tab_seen;
    ipv4tp_pkg::out_item_t pending_lines[$];
    int errors, results_seen, ok_lines, bad_len_lines, bad_octet_lines;
    int first_hits, pair_hits, any_hits;

    function new();
      first_key = ipv4tp_pkg::FIRST_KEY_RST;
      pair_hi   = ipv4tp_pkg::PAIR_KEY_HIGH_RST;
      pair_lo   = ipv4tp_pkg::PAIR_KEY_LOW_RST;
      any_key   = ipv4tp_pkg::ANY_KEY_RST;
      clear_line();
    endfunction

    function void clear_line();
      addr_acc  = '0;
      octets    = 0;
      cur_val   = 0;
      field_len = 0;
      ovf       = 0;
      in_digits = 0;
      failed    = 0;
      tab_seen  = 0;
    endfunction

    function void close_octet();
      if (ovf) begin
        failed = 1;
      end else begin
        addr_acc |= 32'(cur_val & 255) << ((3 - octets) * 8);
        octets++;
      end
      in_digits = 0;
      ovf       = 0;
      cur_val   = 0;
    endfunction

    function void set_key(ipv4tp_pkg::cfg_reg_t idx, logic [ipv4tp_pkg::KEY_W-1:0] val);
      case (idx)
        ipv4tp_pkg::REG_FIRST_KEY:     first_key = val;
        ipv4tp_pkg::REG_PAIR_KEY_HIGH: pair_hi   = val;
        ipv4tp_pkg::REG_PAIR_KEY_LOW:  pair_lo   = val;
        ipv4tp_pkg::REG_ANY_KEY:       any_key   = val;
        default: ;
      endcase
    endfunction

    function void note_char(ipv4tp_pkg::in_item_t it);
      ipv4tp_pkg::out_item_t want;
      logic [ipv4tp_pkg::ADDR_W-1:0] addr;
      bit digit;
      int v;
      digit = (it.char_code >= ipv4tp_pkg::CHAR_ZERO) && (it.char_code <= ipv4tp_pkg::CHAR_NINE);
      if (!tab_seen) begin
        if (it.char_code == ipv4tp_pkg::TAB_CODE) begin
          tab_seen = 1;
        end else begin
          if (field_len < ipv4tp_pkg::LEN_SAT) field_len++;
          if (!failed && octets < ipv4tp_pkg::NUM_OCTETS) begin
            if (in_digits) begin
              if (digit) begin
                v = cur_val * 10 + (int'(it.char_code) - int'(ipv4tp_pkg::CHAR_ZERO));
                if (v > 255) ovf = 1;
                cur_val = v & 255;
              end else begin
                close_octet();
              end
            end else if (digit) begin
              in_digits = 1;
              cur_val   = int'(it.char_code) - int'(ipv4tp_pkg::CHAR_ZERO);
              ovf       = 0;
            end else begin
              failed = 1;
            end
          end
        end
      end
      if (!it.line_end) return;

      if (!failed && in_digits && octets < ipv4tp_pkg::NUM_OCTETS) close_octet();
      if (octets < ipv4tp_pkg::NUM_OCTETS) failed = 1;
      if (field_len < ipv4tp_pkg::MIN_LEN || field_len > ipv4tp_pkg::MAX_LEN) begin
        addr = '0;
        want.status = ipv4tp_pkg::ST_BAD_LEN;
        bad_len_lines++;
      end else begin
        addr = addr_acc;
        want.status = failed ? ipv4tp_pkg::ST_BAD_OCTET : ipv4tp_pkg::ST_OK;
        if (failed) bad_octet_lines++;
        else ok_lines++;
      end
      want.address     = addr;
      want.match_first = (addr[31:24] == first_key);
      want.match_pair  = (addr[31:24] == pair_hi) && (addr[23:16] == pair_lo);
      want.match_any   = (addr[31:24] == any_key) || (addr[23:16] == any_key) ||
                         (addr[15:8] == any_key) || (addr[7:0] == any_key);
      first_hits += want.match_first;
      pair_hits  += want.match_pair;
      any_hits   += want.match_any;
      pending_lines = {pending_lines, want};
      clear_line();
    endfunction

    function void report(string field, logic [ipv4tp_pkg::ADDR_W-1:0] want_v,
                         logic [ipv4tp_pkg::ADDR_W-1:0] got_v);
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want_v, got_v);
    endfunction

    function void check_result(ipv4tp_pkg::out_item_t got);
      ipv4tp_pkg::out_item_t want;
      if (pending_lines.size() == 0) begin
        errors++;
        $display("%0t: unexpected result beat, expected none, actual %h", $time, got);
        return;
      end
      want = pending_lines.pop_front();
      results_seen++;
      if (got.address !== want.address) report("address", want.address, got.address);
      if (got.status !== want.status) report("status", want.status, got.status);
      if (got.match_first !== want.match_first)
        report("match_first", want.match_first, got.match_first);
      if (got.match_pair !== want.match_pair)
        report("match_pair", want.match_pair, got.match_pair);
      if (got.match_any !== want.match_any)
        report("match_any", want.match_any, got.match_any);
    endfunction

    function void flush_leftover();
      ipv4tp_pkg::out_item_t want;
      while (pending_lines.size() != 0) begin
        want = pending_lines.pop_front();
        errors++;
        $display("%0t: missing result, expected %h, actual none", $time, want);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_push = 1'b0;
  logic in_full;
  ipv4tp_pkg::in_item_t in_item = '0;
  logic out_empty;
  logic out_pop = 1'b0;
  ipv4tp_pkg::out_item_t out_item;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [ipv4tp_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [ipv4tp_pkg::KEY_W-1:0] cfg_data = '0;

  ipv4_addr_checker scoreboard = new();
  logic [ipv4tp_pkg::CHAR_W-1:0] line_buf[$];
  int cycle_count = 0;
  int chars_sent = 0;
  int lines_sent = 0;
  int hold_left = 0;
  int pop_stall = 0;
  bit quiet = 0;
  bit hold_armed = 0;
  bit hold_done = 0;

  string directed_lines[] = '{
    "1.2.3.4", "46.70.46.70", "255.255.255.255", "256.1.1.1", "1.300.2.3",
    "1.2.3.4567", "0001.02.003.4", "1.2.3", "1234567890123456", "1.2.3.4\tjunk",
    "\t1.2.3.4", "1a2b3c4", ".1.2.3.4", "1..2.3.4", "1.2.3.4.5.6", "10.20.30",
    "1.2.3.x9", "x", "1.2.3.4.", "\t", "1.2.3.4\t",
    "00000000000000000000000000000001.2.3.4"
  };

  ipv4_text_parse_and_match dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_item   (in_item),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles.", cycle_count);
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_push && !in_full) scoreboard.note_char(in_item);
    if (rst_n && out_pop && !out_empty) scoreboard.check_result(out_item);
  end

  // The result side stalls in random bursts and holds off once for a long stretch.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else if (hold_armed && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= 400;
      out_pop   <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_pop   <= 1'b0;
    end else if (pop_stall != 0) begin
      pop_stall <= pop_stall - 1;
      out_pop   <= 1'b0;
    end else if (!quiet && $urandom_range(0, 9) == 0) begin
      pop_stall <= $urandom_range(0, 18);
      out_pop   <= 1'b0;
    end else begin
      out_pop <= 1'b1;
    end
  end

  task automatic send_char(input logic [ipv4tp_pkg::CHAR_W-1:0] c, input logic last);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_push <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_push <= 1'b1;
    in_item <= '{char_code: c, line_end: last};
    do @(posedge clk); while (in_full);
    chars_sent++;
  endtask

  task automatic send_line();
    for (int i = 0; i < line_buf.size(); i++) send_char(line_buf[i], i == line_buf.size() - 1);
    lines_sent++;
  endtask

  task automatic wait_idle(input int settle);
    while (scoreboard.results_seen < lines_sent) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_keys(input logic [ipv4tp_pkg::KEY_W-1:0] k_first, k_high, k_low, k_any);
    ipv4tp_pkg::cfg_reg_t regs[4] = '{ipv4tp_pkg::REG_FIRST_KEY, ipv4tp_pkg::REG_PAIR_KEY_HIGH,
                                      ipv4tp_pkg::REG_PAIR_KEY_LOW, ipv4tp_pkg::REG_ANY_KEY};
    logic [ipv4tp_pkg::KEY_W-1:0] vals[4];
    vals = '{k_first, k_high, k_low, k_any};
    for (int i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= regs[i];
      cfg_data  <= vals[i];
      do @(posedge clk); while (!cfg_ready);
      scoreboard.set_key(regs[i], vals[i]);
    end
    cfg_valid <= 1'b0;
  endtask

  function automatic void load_text(string s);
    line_buf.delete();
    for (int i = 0; i < s.len(); i++) line_buf = {line_buf, s[i]};
  endfunction

  // Mostly well-formed addresses with random content; some are mutated or pure noise.
  function automatic void build_random_line();
    int oct[4];
    int r;
    int c;
    int kind;
    string txt;
    kind = $urandom_range(0, 9);
    for (int k = 0; k < 4; k++) begin
      r = $urandom_range(0, 9);
      if (r < 3) begin
        case ($urandom_range(0, 3))
          0: oct[k] = scoreboard.first_key;
          1: oct[k] = scoreboard.pair_hi;
          2: oct[k] = scoreboard.pair_lo;
          default: oct[k] = scoreboard.any_key;
        endcase
      end else if (r == 3) begin
        oct[k] = $urandom_range(256, 999);
      end else begin
        oct[k] = $urandom_range(0, 255);
      end
    end
    if ($urandom_range(0, 3) == 0) begin
      oct[0] = scoreboard.pair_hi;
      oct[1] = scoreboard.pair_lo;
    end
    line_buf.delete();
    for (int k = 0; k < 4; k++) begin
      if ($urandom_range(0, 4) == 0)
        repeat ($urandom_range(1, 3)) line_buf = {line_buf, ipv4tp_pkg::CHAR_ZERO};
      txt = $sformatf("%0d", oct[k]);
      for (int i = 0; i < txt.len(); i++) line_buf = {line_buf, txt[i]};
      if (k < 3) begin
        if ($urandom_range(0, 7) == 0) begin
          c = $urandom_range(0, 245);
          if (c >= 48) c += 10;
          line_buf = {line_buf, 8'(c)};
        end else begin
          line_buf = {line_buf, DOT_CHAR};
        end
      end
    end
    case ($urandom_range(0, 3))
      1: begin
        line_buf = {line_buf, ipv4tp_pkg::TAB_CODE};
        repeat ($urandom_range(0, 6)) line_buf = {line_buf, 8'($urandom_range(0, 255))};
      end
      2: repeat ($urandom_range(1, 4)) line_buf = {line_buf, 8'($urandom_range(0, 255))};
      default: ;
    endcase
    if (kind == 7) begin
      line_buf[$urandom_range(0, line_buf.size() - 1)] = 8'($urandom_range(0, 255));
    end else if (kind >= 8) begin
      line_buf.delete();
      repeat ($urandom_range(1, 24)) line_buf = {line_buf, 8'($urandom_range(0, 255))};
    end
  endfunction

  initial begin
    int phase_start;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_lines[i]) begin
      load_text(directed_lines[i]);
      send_line();
    end
    load_text("9.8.7.6 ");
    line_buf = {line_buf, 8'hFF};
    line_buf = {line_buf, 8'h00};
    send_line();
    in_push <= 1'b0;
    wait_idle(4);

    for (int p = 0; p < 6; p++) begin
      case (p)
        0: write_keys(8'd0, 8'd0, 8'd0, 8'd0);
        1: write_keys(8'd255, 8'd255, 8'd255, 8'd255);
        default: write_keys(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                            8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      endcase
      if (p == 1) hold_armed = 1;
      if (p == 5) quiet = 1;
      phase_start = chars_sent;
      if (p == 0) begin
        load_text("0.0.0.0");
        send_line();
      end else if (p == 1) begin
        load_text("255.255.255.255");
        send_line();
      end
      while (chars_sent - phase_start < 95) begin
        build_random_line();
        send_line();
      end
      in_push <= 1'b0;
      wait_idle(8);
    end

    scoreboard.flush_leftover();
    $display("Checked %0d lines over %0d characters: %0d ok, %0d bad length, %0d bad octet.",
             scoreboard.results_seen, chars_sent, scoreboard.ok_lines,
             scoreboard.bad_len_lines, scoreboard.bad_octet_lines);
    $display("Key matches seen under reset and six key settings: first %0d, pair %0d, any %0d.",
             scoreboard.first_hits, scoreboard.pair_hits, scoreboard.any_hits);
    if (scoreboard.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
